>>> hw/rtl/sha256_pkg.sv
package sha256_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] message_byte;
	} sha_req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_rsp_t;

	typedef struct packed {
		logic load_byte;
		logic pad_first;
		logic zero_block;
		logic put_length;
		logic start_block;
		logic round_step;
		logic fold;
		logic reset_chain;
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       round_last;
	} sha_sts_t;

	localparam logic [255:0] HashInit = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [2047:0] RoundK = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

>>> hw/rtl/sha256_byte_stream_hasher_core.sv
// SHA-256 hasher taking a message one byte per request.
// in channel (in_valid/in_ready, in_data): mode 0 appends message_byte,
// mode 1 finishes the message and produces the digest.
// out channel (out_valid/out_ready, out_data): eight digest words, index 0
// first, last_word set on index 7.
// A data byte that completes a 64-byte block starts a compression
// (one round per cycle in the shared round unit, plus load and fold).
// A finish runs one or two block compressions before the first word,
// then one word per cycle while out_ready is high.
// in_ready is low while compressing or while digest words wait; a stalled
// receiver simply holds the current word. After the last word the chaining
// value and length return to their initial values.
// Reset clears the controller, length and chaining value at once.
module sha256_byte_stream_hasher_core
	import sha256_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sha_req_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output sha_rsp_t out_data
);
	sha_cmd_t    cmd;
	sha_sts_t    sts;
	logic [2:0]  idx;
	logic [31:0] word;

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_mode(in_data.mode), .in_ready,
		.out_ready, .out_valid, .out_idx(idx), .sts, .cmd);

	sha256_dp u_dp (
		.clk, .arst_n, .cmd, .data_byte(in_data.message_byte), .rd_idx(idx),
		.sts, .chain_word(word));

	assign out_data.digest_word = word;
	assign out_data.word_index = idx;
	assign out_data.last_word = (idx == 3'd7);
endmodule

>>> hw/rtl/sha256_dp.sv
module sha256_dp
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sha_cmd_t    cmd,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  rd_idx,
	output sha_sts_t    sts,
	output logic [31:0] chain_word
);
	// message block is gathered straight into the 16-word schedule window
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [31:0] w_new, t1, t2, wm2, wm15, s0, s1;
	logic [3:0]  ti;
	logic [5:0]  pos;

	assign pos = len_q[8:3];
	assign ti = rnd_q[3:0];
	assign sts.pos = pos;
	assign sts.round_last = (rnd_q == 6'd63);
	assign chain_word = h_q[rd_idx];

	always_comb begin
		wm2  = w_q[4'(ti - 4'd2)];
		wm15 = w_q[4'(ti - 4'd15)];
		s1 = rotr(wm2, 17) ^ rotr(wm2, 19) ^ (wm2 >> 10);
		s0 = rotr(wm15, 7) ^ rotr(wm15, 18) ^ (wm15 >> 3);
		if (!rnd_q[5] && !rnd_q[4])
			w_new = w_q[ti];
		else
			w_new = s1 + w_q[4'(ti - 4'd7)] + s0 + w_q[ti];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6])) + RoundK[2047 - 32*rnd_q -: 32] + w_new;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= HashInit[255 - 32*i -: 32];
				v_q[i] <= '0;
			end
		end else begin
			if (cmd.load_byte) len_q <= len_q + 64'd8;
			if (cmd.start_block) begin
				rnd_q <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			if (cmd.round_step) begin
				rnd_q <= rnd_q + 6'd1;
				for (int i = 1; i < 8; i++) v_q[i] <= v_q[i-1];
				v_q[4] <= v_q[3] + t1;
				v_q[0] <= t1 + t2;
			end
			if (cmd.fold)
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			if (cmd.reset_chain) begin
				len_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= HashInit[255 - 32*i -: 32];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round_step) w_q[ti] <= w_new;
		if (cmd.load_byte) w_q[pos[5:2]][31 - 8*pos[1:0] -: 8] <= data_byte;
		if (cmd.pad_first)
			for (int i = 0; i < 16; i++)
				for (int j = 0; j < 4; j++)
					if (6'(4*i + j) == pos)
						w_q[i][31 - 8*j -: 8] <= 8'h80;
					else if (6'(4*i + j) > pos && !(cmd.put_length && i >= 14))
						w_q[i][31 - 8*j -: 8] <= 8'h00;
		if (cmd.zero_block)
			for (int i = 0; i < 14; i++) w_q[i] <= '0;
		if (cmd.put_length) begin
			w_q[14] <= len_q[63:32];
			w_q[15] <= len_q[31:0];
		end
	end
endmodule

>>> hw/rtl/sha256_ctrl.sv
module sha256_ctrl
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_mode,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [2:0] out_idx,
	input  sha_sts_t   sts,
	output sha_cmd_t   cmd
);
	localparam logic [2:0] S_IDLE = 3'd0, S_START = 3'd1, S_ROUND = 3'd2, S_FOLD = 3'd3,
		S_PAD2 = 3'd4, S_OUT = 3'd5;

	logic [2:0] state_q, state_d;
	logic       fin_q, fin_d, two_q, two_d;
	logic [2:0] idx_q, idx_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_idx = idx_q;

	always_comb begin
		state_d = state_q;
		fin_d = fin_q;
		two_d = two_q;
		idx_d = idx_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!in_mode) begin
						cmd.load_byte = 1'b1;
						fin_d = 1'b0;
						if (sts.pos == 6'd63) state_d = S_START;
					end else begin
						cmd.pad_first = 1'b1;
						fin_d = 1'b1;
						two_d = (sts.pos >= 6'd56);
						if (sts.pos < 6'd56) cmd.put_length = 1'b1;
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start_block = 1'b1;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.round_step = 1'b1;
				if (sts.round_last) state_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (!fin_q) state_d = S_IDLE;
				else if (two_q) state_d = S_PAD2;
				else begin
					idx_d = '0;
					state_d = S_OUT;
				end
			end
			S_PAD2: begin
				cmd.zero_block = 1'b1;
				cmd.put_length = 1'b1;
				two_d = 1'b0;
				state_d = S_START;
			end
			S_OUT: begin
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reset_chain = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q <= 1'b0;
			two_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			two_q <= two_d;
			idx_q <= idx_d;
		end
	end
endmodule

>>> hw/rtl/sha256_chk.sv
module sha256_chk
	import sha256_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input sha_rsp_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("ready during output");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_word |=>
		out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
		else $error("word order");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.last_word == (out_data.word_index == 3'd7))
		else $error("last flag");
endmodule

bind sha256_byte_stream_hasher_core sha256_chk u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data);

>>> verif/tb.sv
module tb;
	import sha256_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	sha_req_t in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	sha_rsp_t out_data;

	localparam logic MODE_DATA = 1'b0;
	localparam logic MODE_FINISH = 1'b1;
	localparam int CYCLE_LIMIT = 400000;

	always #6 clk = ~clk;

	sha256_byte_stream_hasher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] KT [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	logic [63:0] msg_bits;

	sha_req_t pending_reqs [$];
	int       pause_marks [$];
	sha_rsp_t digest_words [$];
	bit       failed = 1'b0;
	bit       stim_done = 1'b0;
	int       sent = 0;
	int       cycles = 0;

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			a[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = a[7] + (ror(a[4], 6) ^ ror(a[4], 11) ^ ror(a[4], 25))
				+ ((a[4] & a[5]) | (~a[4] & a[6])) + KT[i] + w[i];
			t2 = (ror(a[0], 2) ^ ror(a[0], 13) ^ ror(a[0], 22))
				+ ((a[0] & a[1]) | (a[0] & a[2]) | (a[1] & a[2]));
			a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
			a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += a[i];
	endtask

	task automatic predict_digest(input sha_req_t r);
		int pos;
		sha_rsp_t rsp;
		pos = msg_bits[8:3];
		if (r.mode == MODE_DATA) begin
			msg_block[pos] = r.message_byte;
			msg_bits += 64'd8;
			if (pos == 63)
				compress();
			return;
		end
		msg_block[pos] = 8'h80;
		for (int i = pos + 1; i < 64; i++)
			msg_block[i] = '0;
		if (pos >= 56) begin
			compress();
			for (int i = 0; i < 56; i++)
				msg_block[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = msg_bits[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			rsp.digest_word = hash_state[i];
			rsp.word_index = 3'(i);
			rsp.last_word = (i == 7);
			digest_words.push_back(rsp);
		end
		hash_state = IV;
		msg_bits = '0;
	endtask

	function automatic sha_req_t data_req(input logic [7:0] b);
		sha_req_t r;
		r.mode = MODE_DATA;
		r.message_byte = b;
		return r;
	endfunction

	function automatic sha_req_t finish_req(input logic [7:0] b);
		sha_req_t r;
		r.mode = MODE_FINISH;
		r.message_byte = b;
		return r;
	endfunction

	// driver: bursts and gaps, holds off at marked request counts until drained
	int  gap = 0;
	int  burst = 0;
	bit  holding = 1'b0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && in_ready) begin
			predict_digest(in_data);
			sent <= sent + 1;
		end
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (pause_marks.size() != 0 && pause_marks[0] == sent + (in_valid && in_ready)) begin
				holding = 1'b1;
				void'(pause_marks.pop_front());
			end
			if (holding && digest_words.size() == 0 && !(in_valid && in_ready)
				&& !out_valid)
				holding = 1'b0;
			if (holding || pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_data <= pending_reqs.pop_front();
				if (burst > 0)
					burst--;
				else begin
					burst = $urandom_range(0, 20);
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// monitor and receiver stall pattern
	logic [7:0] stall_pat = 8'b1011_0111;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (digest_words.size() == 0) begin
				$error("digest word with none expected: %h", out_data.digest_word);
				failed = 1'b1;
			end else begin
				sha_rsp_t e;
				e = digest_words.pop_front();
				if (out_data.digest_word !== e.digest_word) begin
					$error("digest_word exp %h got %h", e.digest_word, out_data.digest_word);
					failed = 1'b1;
				end
				if (out_data.word_index !== e.word_index) begin
					$error("word_index exp %0d got %0d", e.word_index, out_data.word_index);
					failed = 1'b1;
				end
				if (out_data.last_word !== e.last_word) begin
					$error("last_word exp %0d got %0d", e.last_word, out_data.last_word);
					failed = 1'b1;
				end
			end
		end
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0)
				stall_pat <= 8'($urandom);
			else
				stall_pat <= {stall_pat[6:0], stall_pat[7]};
			out_ready <= (cycles % 600 < 150) ? 1'b1 : stall_pat[0];
		end
	end

	initial begin
		int n;
		hash_state = IV;
		msg_bits = '0;
		// empty message with junk byte on finish
		pending_reqs.push_back(finish_req(8'hff));
		// "abc"
		pending_reqs.push_back(data_req(8'h61));
		pending_reqs.push_back(data_req(8'h62));
		pending_reqs.push_back(data_req(8'h63));
		pending_reqs.push_back(finish_req(8'h00));
		pause_marks.push_back(5);
		// byte extremes
		pending_reqs.push_back(data_req(8'h00));
		pending_reqs.push_back(data_req(8'hff));
		pending_reqs.push_back(data_req(8'h55));
		pending_reqs.push_back(data_req(8'haa));
		pending_reqs.push_back(finish_req(8'h5a));
		// 56 bytes: padding spills into an extra block
		for (int i = 0; i < 56; i++)
			pending_reqs.push_back(data_req($urandom));
		pending_reqs.push_back(finish_req($urandom));
		// 64 bytes: full block then pad block
		for (int i = 0; i < 64; i++)
			pending_reqs.push_back(data_req($urandom));
		pending_reqs.push_back(finish_req($urandom));
		pause_marks.push_back(pending_reqs.size());
		// random messages, mostly short, a few crossing block edges
		n = pending_reqs.size();
		while (n < 170) begin
			int len;
			case ($urandom_range(0, 5))
				0: len = $urandom_range(55, 65);
				1: len = $urandom_range(100, 130);
				default: len = $urandom_range(0, 12);
			endcase
			if (len > 169 - n)
				len = 169 - n;
			for (int i = 0; i < len; i++)
				pending_reqs.push_back(data_req($urandom));
			pending_reqs.push_back(finish_req($urandom));
			n += len + 1;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (digest_words.size() == 0);
		repeat (200) @(posedge clk);
		if (!failed && digest_words.size() == 0)
			$display("[sha256_byte_stream_hasher_core] OK");
		else
			$display("[sha256_byte_stream_hasher_core] ERROR");
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("[sha256_byte_stream_hasher_core] ERROR");
		$finish;
	end
endmodule
